// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on a given clock, disabled while the given reset is low
`define NSP_ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("nsp assertion failed");

// assertion on the standard clock and reset
`define NSP_ASSERT(label, prop) `NSP_ASSERT_AT(label, clk_i, rst_ni, prop)

`endif

// ----- rtl/core/nsp_pkg.sv -----
// types and constants of the note sequence player
package nsp_pkg;

  localparam int unsigned ActionW  = 3;
  localparam int unsigned DeltaW   = 16;
  localparam int unsigned IndexW   = 8;
  localparam int unsigned PitchW   = 7;
  localparam int unsigned DurW     = 16;
  localparam int unsigned EventW   = 2;
  localparam int unsigned SongLenW = 9;

  typedef enum logic [ActionW-1:0] {
    ACT_TICK    = 3'd0,
    ACT_WRITE   = 3'd1,
    ACT_RESTART = 3'd2,
    ACT_PLAY    = 3'd3,
    ACT_PAUSE   = 3'd4
  } action_e;

  typedef enum logic [EventW-1:0] {
    EV_NONE  = 2'd0,
    EV_START = 2'd1,
    EV_STOP  = 2'd2
  } event_e;

  typedef struct packed {
    logic [PitchW-1:0] pitch;
    logic [DurW-1:0]   sustain;
    logic [DurW-1:0]   silence;
  } note_t;

  typedef struct packed {
    logic load;
    logic commit;
  } nsp_cmd_t;

endpackage

// ----- rtl/core/nsp_in_if.sv -----
// input channel: valid, ready and one input transaction
interface nsp_in_if import nsp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ActionW-1:0]  action;
  logic [DeltaW-1:0]   delta_ms;
  logic [IndexW-1:0]   entry_index;
  logic [PitchW-1:0]   entry_pitch;
  logic [DurW-1:0]     entry_sustain_ms;
  logic [DurW-1:0]     entry_silence_ms;

  modport source (
    output valid, action, delta_ms, entry_index, entry_pitch, entry_sustain_ms,
    entry_silence_ms,
    input  ready
  );
  modport sink (
    input  valid, action, delta_ms, entry_index, entry_pitch, entry_sustain_ms,
    entry_silence_ms,
    output ready
  );
endinterface

// ----- rtl/core/nsp_out_if.sv -----
// output channel: valid, ready and one result transaction
interface nsp_out_if import nsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [EventW-1:0] event_res;
  logic [PitchW-1:0] pitch_out;
  logic              is_paused;

  modport source (
    output valid, event_res, pitch_out, is_paused,
    input  ready
  );
  modport sink (
    input  valid, event_res, pitch_out, is_paused,
    output ready
  );
endinterface

// ----- rtl/core/nsp_ctrl.sv -----
// controller: transaction handshakes and sequencing of the datapath
`include "assert_macros.svh"
module nsp_ctrl import nsp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output nsp_cmd_t cmd_o
);

  typedef enum logic {ST_IDLE, ST_EXEC} state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   commit;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign commit       = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  assign cmd_o.load   = in_valid_i && in_ready_o;
  assign cmd_o.commit = commit;
  assign out_valid_o  = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.load) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (commit) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `NSP_ASSERT(a_accept_then_busy, cmd_o.load |=> !in_ready_o)
  `NSP_ASSERT(a_commit_gives_result, cmd_o.commit |=> out_valid_o)
  `NSP_ASSERT(a_result_from_exec, $rose(out_valid_q) |-> $past(state_q == ST_EXEC))

endmodule

// ----- rtl/core/nsp_dp.sv -----
// datapath: note table, play position, countdown counters and result register
`include "assert_macros.svh"
module nsp_dp import nsp_pkg::*; #(
  parameter int MAX_NOTES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nsp_cmd_t            cmd_i,
  input  logic                cfg_we_i,
  input  logic [SongLenW-1:0] cfg_wdata_i,
  input  logic [ActionW-1:0]  action_i,
  input  logic [DeltaW-1:0]   delta_ms_i,
  input  logic [IndexW-1:0]   entry_index_i,
  input  logic [PitchW-1:0]   entry_pitch_i,
  input  logic [DurW-1:0]     entry_sustain_ms_i,
  input  logic [DurW-1:0]     entry_silence_ms_i,
  output logic [EventW-1:0]   event_res_o,
  output logic [PitchW-1:0]   pitch_out_o,
  output logic                is_paused_o
);

  localparam int AddrW  = $clog2(MAX_NOTES);
  localparam int LenMax = (2 ** SongLenW) - 1;
  localparam logic [SongLenW-1:0] LenCap =
    (MAX_NOTES > LenMax) ? SongLenW'(LenMax) : SongLenW'(MAX_NOTES);

  note_t mem [MAX_NOTES];

  logic [SongLenW-1:0] song_len_q;
  logic [SongLenW-1:0] pos_q, pos_d;
  logic [DurW-1:0]     sus_q, sus_d;
  logic [DurW-1:0]     sil_q, sil_d;
  logic                paused_q, paused_d;
  action_e             act_q;
  logic [DeltaW-1:0]   delta_q;
  note_t               rd0_q, rd1_q;
  logic [EventW-1:0]   ev_q;
  logic [PitchW-1:0]   pitch_q;
  event_e              ev_d;
  logic [PitchW-1:0]   pitch_d;

  action_e             act_in;
  logic [SongLenW-1:0] eff_len;
  logic [SongLenW-1:0] pos_inc;
  logic [AddrW-1:0]    ra0, ra1;
  logic                wr_ok;

  assign act_in  = action_e'(action_i);
  assign eff_len = (song_len_q > LenCap) ? LenCap : song_len_q;
  assign pos_inc = pos_q + SongLenW'(1);
  assign ra0     = (act_in == ACT_RESTART) ? '0 : AddrW'(pos_q);
  assign ra1     = AddrW'(pos_inc);
  assign wr_ok   = (32'(entry_index_i) < MAX_NOTES);

  // note table
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (act_in == ACT_WRITE) && wr_ok) begin
      mem[AddrW'(entry_index_i)] <= '{pitch: entry_pitch_i, sustain: entry_sustain_ms_i,
                                      silence: entry_silence_ms_i};
    end
    if (cmd_i.load) begin
      rd0_q <= mem[ra0];
      rd1_q <= mem[ra1];
    end
  end

  // captured transaction fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= act_in;
      delta_q <= delta_ms_i;
    end
  end

  always_comb begin
    pos_d    = pos_q;
    sus_d    = sus_q;
    sil_d    = sil_q;
    paused_d = paused_q;
    ev_d     = EV_NONE;
    pitch_d  = '0;
    case (act_q)
      ACT_TICK: begin
        if (!paused_q) begin
          if (pos_q >= eff_len) begin
            paused_d = 1'b1;
            ev_d     = EV_STOP;
          end else if (sus_q != '0) begin
            if (sus_q == rd0_q.sustain) begin
              ev_d    = EV_START;
              pitch_d = rd0_q.pitch;
            end
            sus_d = (delta_q >= sus_q) ? '0 : sus_q - delta_q;
          end else if (sil_q != '0) begin
            if (sil_q == rd0_q.silence) ev_d = EV_STOP;
            sil_d = (delta_q >= sil_q) ? '0 : sil_q - delta_q;
          end else begin
            pos_d = pos_inc;
            if (pos_inc < eff_len) begin
              sus_d = rd1_q.sustain;
              sil_d = rd1_q.silence;
            end
          end
        end
      end
      ACT_RESTART: begin
        pos_d = '0;
        if (eff_len != '0) begin
          sus_d = rd0_q.sustain;
          sil_d = rd0_q.silence;
        end
      end
      ACT_PLAY: paused_d = 1'b0;
      ACT_PAUSE: begin
        if (!paused_q) ev_d = EV_STOP;
        paused_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      song_len_q <= '0;
      pos_q      <= '0;
      sus_q      <= '0;
      sil_q      <= '0;
      paused_q   <= 1'b1;
    end else begin
      if (cfg_we_i) song_len_q <= cfg_wdata_i;
      if (cmd_i.commit) begin
        pos_q    <= pos_d;
        sus_q    <= sus_d;
        sil_q    <= sil_d;
        paused_q <= paused_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      ev_q    <= ev_d;
      pitch_q <= pitch_d;
    end
  end

  assign event_res_o = ev_q;
  assign pitch_out_o = pitch_q;
  assign is_paused_o = paused_q;

  `NSP_ASSERT(a_pos_bounded, pos_q <= LenCap)

endmodule

// ----- rtl/core/note_sequence_player.sv -----
// note sequence player top level
//
//   channel  dir  handshake          contents
//   in_i     in   valid/ready        action, delta, table entry fields
//   out_o    out  valid/ready        event, pitch, pause flag
//   cfg      in   cfg_we_i only      song length
//
// every transaction reads the table on accept, then updates the state in ST_EXEC
// the table has a registered dual read port, both entries fetched at accept
// a finished result waits in the output register while the next transaction is taken
// a stalled output holds the update cycle until the result is taken
// reset returns to paused at position 0; the table keeps no reset
module note_sequence_player import nsp_pkg::*; #(
  parameter int MAX_NOTES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SongLenW-1:0] cfg_wdata_i,
  nsp_in_if.sink              in_i,
  nsp_out_if.source           out_o
);

  nsp_cmd_t cmd;

  nsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  nsp_dp #(
    .MAX_NOTES (MAX_NOTES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .action_i           (in_i.action),
    .delta_ms_i         (in_i.delta_ms),
    .entry_index_i      (in_i.entry_index),
    .entry_pitch_i      (in_i.entry_pitch),
    .entry_sustain_ms_i (in_i.entry_sustain_ms),
    .entry_silence_ms_i (in_i.entry_silence_ms),
    .event_res_o        (out_o.event_res),
    .pitch_out_o        (out_o.pitch_out),
    .is_paused_o        (out_o.is_paused)
  );

endmodule
